### rtl/core/bel_pkg.sv
// Package with shared types and constants of the envelope limiter.
`timescale 1ns / 1ps
package bel_pkg;
	localparam int SAMPLE_W = 16;
	localparam int ENV_W = 16;
	localparam int QUOT_W = 17;
	localparam logic [15:0] ATTACK_RESET = 16'd65000;
	localparam logic [15:0] RELEASE_RESET = 16'd65500;
	localparam logic [15:0] THRESH_RESET = 16'd52428;
	localparam logic [1:0] REG_ATTACK = 2'd0;
	localparam logic [1:0] REG_RELEASE = 2'd1;
	localparam logic [1:0] REG_THRESH = 2'd2;

	// Control handed from the top level to each lane.
	typedef struct packed {
		logic start;
		logic active;
		logic [16:0] divisor;
	} bel_lane_ctl_t;
endpackage

### rtl/core/bel_lane.sv
// One channel lane: envelope tracking and a restoring serial divider.
`timescale 1ns / 1ps
module bel_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic track,
	input  logic signed [15:0] sample,
	input  logic [15:0] attack_coeff,
	input  logic [15:0] release_coeff,
	output logic [15:0] env,
	input  bel_pkg::bel_lane_ctl_t ctl,
	input  logic signed [15:0] div_sample,
	output logic busy,
	output logic signed [15:0] result
);
	import bel_pkg::*;

	logic [15:0] env_q;
	logic [16:0] mag;
	logic [15:0] m;
	logic [15:0] g;
	logic [16:0] gc;
	logic [33:0] acc;
	logic [16:0] rem_q;
	logic [15:0] quo_q;
	logic [4:0] cnt_q;
	logic neg_q;
	logic [17:0] rem_sh;
	logic [31:0] prod_a;
	logic [32:0] prod_b;

	// Magnitude is 2*|x| saturated at 65535.
	always_comb begin
		mag = sample[15] ? (17'd0 - {sample[15], sample}) : {1'b0, sample};
		m = (mag[16:15] != 2'b00) ? 16'hFFFF : {mag[14:0], 1'b0};
		g = (env_q < m) ? attack_coeff : release_coeff;
		gc = 17'h10000 - {1'b0, g};
		prod_a = g * env_q;
		prod_b = gc * m;
		acc = {2'b00, prod_a} + {1'b0, prod_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (track) begin
			env_q <= acc[31:16];
		end
	end
	assign env = env_q;

	// |x|*65536 / divisor: the remainder starts at |x|, which is already below
	// the divisor, so only the 16 low zero bits of the numerator yield quotient
	// bits, one per cycle.
	assign rem_sh = {rem_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start && ctl.active) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q <= div_sample[15];
			rem_q <= div_sample[15] ? (17'd0 - {div_sample[15], div_sample})
				: {1'b0, div_sample};
			quo_q <= '0;
		end else if (cnt_q != 0) begin
			if (rem_sh >= {1'b0, ctl.divisor}) begin
				rem_q <= 17'(rem_sh - {1'b0, ctl.divisor});
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_sh[16:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign busy = cnt_q != 0;
	assign result = !ctl.active ? div_sample : (neg_q ? -$signed(quo_q) : $signed(quo_q));
endmodule

### rtl/core/block_envelope_limiter.sv
// Top level of the stereo buffered envelope limiter.
`timescale 1ns / 1ps
// Usage: frames enter on s_axis (tdata = left, right; tuser = last_of_buffer).
// Each accepted frame updates the per-channel envelopes and is written
// to the frame store. A frame with the last flag, or the frame that
// fills BUFFER_FRAMES entries, starts the drain: the input then stalls
// while every stored frame leaves on m_axis in order, tlast on the
// final one. Per drained frame the store read is registered, then ST_RD
// latches each lane's divisor and starts the lanes; for a limited
// channel the lane's serial divider then yields one quotient bit a
// cycle, and a merge step joins both lanes' results into one output
// request. Outside a drain, intake takes one frame per cycle.
// An output register holds each result; when the receiver stalls, the
// drain simply waits. Reset clears the envelopes, frame count and
// coefficient registers to their defaults; the store content is left as is.
// Configuration writes on cfg_* are taken at any time, meant while idle;
// an index beyond the register list is ignored.
module block_envelope_limiter #(
	parameter int BUFFER_FRAMES = 64,
	parameter int CHANNELS = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // left_sample[15:0], right_sample[31:16]
	input  logic s_axis_tuser,         // last_of_buffer
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata,  // left_out[15:0], right_out[31:16]
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import bel_pkg::*;

	localparam int AW = (BUFFER_FRAMES > 1) ? $clog2(BUFFER_FRAMES) : 1;
	localparam int CW = $clog2(BUFFER_FRAMES + 1);

	typedef enum logic [3:0] {
		ST_IN = 4'b0001, ST_RD = 4'b0010, ST_DIV = 4'b0100, ST_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [15:0] attack_q, release_q, thresh_q;
	logic [31:0] store_q [BUFFER_FRAMES];
	logic [31:0] rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic in_acc;
	logic [15:0] env0, env1;
	logic [15:0] res0, res1;
	logic busy0, busy1;
	bel_lane_ctl_t ctl0, ctl1;
	logic act0_q, act1_q;
	logic [16:0] div0_q, div1_q;
	logic start_q;
	logic [CW-1:0] cnt_next;
	logic signed [15:0] right_in;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = state_q == ST_IN;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign cnt_next = count_q + 1'b1;
	assign right_in = (CHANNELS >= 2) ? s_axis_tdata[31:16] : 16'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ATTACK_RESET;
			release_q <= RELEASE_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ATTACK: attack_q <= cfg_data;
				REG_RELEASE: release_q <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) store_q[count_q[AW-1:0]] <= {right_in, s_axis_tdata[15:0]};
		rd_q <= store_q[idx_q[AW-1:0]];
	end

	bel_lane u_lane0 (
		.clk, .arst_n, .track(in_acc), .sample(s_axis_tdata[15:0]),
		.attack_coeff(attack_q), .release_coeff(release_q), .env(env0),
		.ctl(ctl0), .div_sample(rd_q[15:0]), .busy(busy0), .result(res0)
	);
	bel_lane u_lane1 (
		.clk, .arst_n, .track(in_acc), .sample(right_in),
		.attack_coeff(attack_q), .release_coeff(release_q), .env(env1),
		.ctl(ctl1), .div_sample(rd_q[31:16]), .busy(busy1), .result(res1)
	);

	assign ctl0 = '{start: start_q, active: act0_q, divisor: div0_q};
	assign ctl1 = '{start: start_q, active: act1_q, divisor: div1_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
			count_q <= '0;
			idx_q <= '0;
			start_q <= 1'b0;
			act0_q <= 1'b0;
			act1_q <= 1'b0;
			div0_q <= '0;
			div1_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IN: if (in_acc) begin
					count_q <= cnt_next;
					if (s_axis_tuser || cnt_next == CW'(BUFFER_FRAMES)) begin
						state_q <= ST_RD;
						idx_q <= '0;
					end
				end
				ST_RD: begin
					// Envelopes are final here; latch per-lane divisor.
					act0_q <= env0 > thresh_q;
					act1_q <= env1 > thresh_q;
					div0_q <= {1'b0, env0} + 17'h10000 - {1'b0, thresh_q};
					div1_q <= {1'b0, env1} + 17'h10000 - {1'b0, thresh_q};
					start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: if (!start_q && !busy0 && !busy1) begin
					// Merge stage: both lanes done, form one result.
					m_axis_tdata <= {(CHANNELS >= 2) ? res1 : 16'd0, res0};
					m_axis_tlast <= idx_q + 1'b1 == count_q;
					m_axis_tvalid <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
					idx_q <= idx_q + 1'b1;
					if (m_axis_tlast) begin
						count_q <= '0;
						state_q <= ST_IN;
					end else begin
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end
endmodule

### rtl/core/bel_checker.sv
// Port-level assertions for the envelope limiter, bound to the top level.
`timescale 1ns / 1ps
module bel_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic [31:0] m_axis_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("intake open while draining");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output request changed under stall");
	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("intake not reopened after last");
endmodule

bind block_envelope_limiter bel_checker u_bel_checker (
	.clk, .arst_n, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tlast, .m_axis_tdata
);

### sim/tb_block_envelope_limiter.sv
// Self-checking testbench for the stereo buffered envelope limiter.
`timescale 1ns / 1ps
module tb_block_envelope_limiter;
	import bel_pkg::*;

	localparam int FRAMES_PER_BUFFER = 64;
	localparam int NUM_CHANNELS = 2;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// One drained frame as the block should emit it.
	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic last;
	} limited_frame_t;

	// Scoreboard: it keeps its own envelopes, coefficients and frame buffer, and
	// queues the limited frames that each buffer drain must produce.
	class limiter_scoreboard;
		logic [15:0] env [2];
		logic [15:0] attack;
		logic [15:0] release_g;
		logic [15:0] thresh;
		logic [15:0] held_left [$];
		logic [15:0] held_right [$];
		limited_frame_t pending [$];
		int errors;

		function void clear();
			env[0] = 0;
			env[1] = 0;
			attack = ATTACK_RESET;
			release_g = RELEASE_RESET;
			thresh = THRESH_RESET;
			held_left.delete();
			held_right.delete();
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_ATTACK: attack = val;
				REG_RELEASE: release_g = val;
				REG_THRESH: thresh = val;
				default: ;
			endcase
		endfunction

		// Peak follower: the attack coefficient applies while the envelope is below
		// the doubled, saturated sample magnitude.
		function logic [15:0] follow(logic [15:0] e, logic signed [15:0] s);
			logic [16:0] mag;
			logic [15:0] m;
			logic [15:0] g;
			logic [47:0] acc;
			mag = (s < 0) ? 17'(-int'(s)) : 17'(s);
			m = (mag * 2 > 65535) ? 16'hFFFF : 16'(mag * 2);
			g = (e < m) ? attack : release_g;
			acc = 48'(g) * e + 48'(65536 - int'(g)) * m;
			return acc[31:16];
		endfunction

		function logic [15:0] scale(logic [15:0] s, bit on, longint div);
			longint num;
			if (!on)
				return s;
			num = longint'($signed(s)) * 65536;
			return 16'(num / div);
		endfunction

		function void note_frame(logic [15:0] l, logic [15:0] r, logic last);
			bit on [2];
			longint div [2];
			limited_frame_t f;
			env[0] = follow(env[0], l);
			if (NUM_CHANNELS >= 2)
				env[1] = follow(env[1], r);
			held_left.push_back(l);
			held_right.push_back(NUM_CHANNELS >= 2 ? r : 16'd0);
			if (!last && held_left.size() < FRAMES_PER_BUFFER)
				return;
			for (int c = 0; c < 2; c++) begin
				on[c] = env[c] > thresh;
				div[c] = longint'(env[c]) + 65536 - longint'(thresh);
			end
			for (int k = 0; k < held_left.size(); k++) begin
				f.left = scale(held_left[k], on[0], div[0]);
				f.right = NUM_CHANNELS >= 2 ? scale(held_right[k], on[1], div[1]) : 16'd0;
				f.last = (k == held_left.size() - 1);
				pending.push_back(f);
			end
			held_left.delete();
			held_right.delete();
		endfunction

		function void check_frame(logic [15:0] l, logic [15:0] r, logic last);
			limited_frame_t f;
			if (pending.size() == 0) begin
				$error("unexpected output request: left %h right %h last %b", l, r, last);
				errors++;
				return;
			end
			f = pending.pop_front();
			if (l !== f.left) begin
				$error("left_out expected %h actual %h", f.left, l);
				errors++;
			end
			if (r !== f.right) begin
				$error("right_out expected %h actual %h", f.right, r);
				errors++;
			end
			if (last !== f.last) begin
				$error("last_out expected %b actual %b", f.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = 0;
	logic s_axis_tuser = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;

	limiter_scoreboard board = new();
	// The receiver stall pattern is switched between phases.
	int stall_mode = 0;
	// The frames left in the current sender burst.
	int burst_left = 0;

	always #6 clk = ~clk;

	block_envelope_limiter #(
		.BUFFER_FRAMES(FRAMES_PER_BUFFER),
		.CHANNELS(NUM_CHANNELS)
	) dut (.*);

	// Receiver: compares every accepted output request, and decides its ready for
	// the next edge from a pattern selected by stall_mode.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				board.check_frame(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ($urandom_range(0, 19) != 0);
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.write_reg(idx, val);
	endtask

	// Sends one frame. Frames come in bursts: after a burst ends the sender waits
	// a random idle gap before valid rises again.
	task automatic send_frame(logic [15:0] l, logic [15:0] r, logic last);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {r, l};
		s_axis_tuser <= last;
		do @(posedge clk); while (!s_axis_tready);
		board.note_frame(l, r, last);
		if (burst_left == 0)
			s_axis_tvalid <= 1'b0;
	endtask

	// Waits until every expected frame has come out, then lets the drain settle.
	task automatic drain_all();
		@(posedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random sample: mostly full scale, with some small values and the extremes.
	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random buffers, short most of the time; the given count ends with a last.
	task automatic random_buffers(int frames);
		int len;
		while (frames > 0) begin
			len = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 12);
			for (int k = 0; k < len && frames > 0; k++) begin
				frames--;
				send_frame(rand_sample(), rand_sample(), k == len - 1 || frames == 0);
			end
		end
	endtask

	initial begin
		board.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset settings: extremes of both channels, a
		// one-frame buffer, and silence with release.
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h0000, 16'hFFFF, 1'b1);
		send_frame(16'h8000, 16'h8000, 1'b1);
		send_frame(16'h0001, 16'h0000, 1'b0);
		send_frame(16'hFFFF, 16'h0001, 1'b1);
		drain_all();

		// Full buffer without a last flag: the sixty-fourth frame drains on its own.
		stall_mode = 1;
		for (int k = 0; k < FRAMES_PER_BUFFER; k++)
			send_frame(16'h7FFF - 16'(k), 16'h8000 + 16'(k), 1'b0);
		drain_all();

		// Instant attack, zero threshold: the final zero frame leaves none limited.
		write_reg(REG_ATTACK, 16'd0);
		write_reg(REG_RELEASE, 16'd0);
		write_reg(REG_THRESH, 16'd0);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_frame(16'h8000, 16'h7FFF, 1'b0);
		send_frame(16'h1234, 16'hEDCC, 1'b0);
		send_frame(16'h0000, 16'h0000, 1'b1);
		drain_all();

		// Frozen envelopes and the largest threshold: nothing is limited.
		write_reg(REG_ATTACK, 16'hFFFF);
		write_reg(REG_RELEASE, 16'hFFFF);
		write_reg(REG_THRESH, 16'hFFFF);
		send_frame(16'h7FFF, 16'h8000, 1'b1);
		drain_all();

		// Random phases over several settings and stall patterns.
		for (int phase = 0; phase < 4; phase++) begin
			stall_mode = phase;
			write_reg(REG_ATTACK, phase == 0 ? 16'd0 : 16'($urandom));
			write_reg(REG_RELEASE, phase == 3 ? 16'hFFFF : 16'($urandom));
			write_reg(REG_THRESH, phase == 1 ? 16'd0 : 16'($urandom_range(0, 65535)));
			random_buffers(14);
			drain_all();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
